>>> rtl/tks_pkg.sv
// Shared types and constants for the streaming top-L sum tracker.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tks_pkg;

  // Field widths of the request and result items.
  localparam int VAL_W       = 31;
  localparam int SUM_W       = 37;
  localparam int KL_W        = 7;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 72;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_POST,
    ST_SCAN_MIN,
    ST_REPLACE,
    ST_SCAN_NEW,
    ST_EMIT
  } tks_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // latch the request, apply restart
    logic insert;      // append the value, grow count and sum
    logic scan_start;  // start a minimum search over the held entries
    logic replace;     // overwrite the smallest entry with the value
    logic emit;        // load the result register
  } tks_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;        // held count has reached the effective limit
    logic v_gt_min;    // latched value is above the found minimum
    logic scan_done;   // minimum search finished, result is valid
    logic scan_busy;   // minimum search in progress
    logic out_free;    // result register can take a new result
  } tks_sts_t;

endpackage

`default_nettype wire

>>> rtl/tks_ctrl.sv
// Controller state machine for the top-L sum tracker.
// Sequences load, insert, minimum search, replace and emit; depends on tks_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tks_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire tks_pkg::tks_sts_t sts,
  output tks_pkg::tks_cmd_t      cmd
);
  import tks_pkg::*;

  tks_state_t state_r;
  tks_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // A full store needs its minimum before the value can be placed.
        if (sts.full) begin
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN_MIN;
        end else begin
          cmd.insert = 1'b1;
          state_nxt  = ST_POST;
        end
      end
      ST_POST: begin
        // The insert may have filled the store; then the minimum is reported.
        if (sts.full) begin
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN_NEW;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SCAN_MIN: begin
        if (sts.scan_done) begin
          state_nxt = ST_REPLACE;
        end
      end
      ST_REPLACE: begin
        // When the value does not beat the minimum, the found minimum stands.
        if (sts.v_gt_min) begin
          cmd.replace    = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN_NEW;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SCAN_NEW: begin
        if (sts.scan_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/tks_dp.sv
// Datapath for the top-L sum tracker: value store, count, sum, minimum search
// and result register. Driven by tks_ctrl commands; depends on tks_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tks_dp #(
  parameter int CAPACITY = 64,
  parameter int LIM_W    = 7
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [LIM_W-1:0]                  lim,
  input  wire logic [tks_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire logic                              in_tuser,
  input  wire tks_pkg::tks_cmd_t                 cmd,
  output tks_pkg::tks_sts_t                      sts,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [tks_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic                                   out_tuser
);
  import tks_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [VAL_W-1:0] mem [CAPACITY];

  logic [CNT_W-1:0] count_r;
  logic [SUM_W-1:0] sum_r;
  logic [VAL_W-1:0] v_r;

  logic             scanning_r;
  logic [CNT_W-1:0] scan_cnt_r;
  logic             rd_vld_r;
  logic             rd_last_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [VAL_W-1:0] rd_data_r;
  logic             scan_done_r;
  logic [VAL_W-1:0] min_r;
  logic [IDX_W-1:0] min_idx_r;

  logic             out_valid_r;
  logic [SUM_W-1:0] out_sum_r;
  logic [VAL_W-1:0] out_min_r;
  logic             out_enough_r;

  logic [LIM_W-1:0] count_ext;
  logic             full;
  logic             enough;
  logic             v_gt_min;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [VAL_W-1:0] smallest;

  // Fill state against the effective limit.
  assign count_ext = LIM_W'(count_r);
  assign full      = (count_ext >= lim);
  assign enough    = ({1'b0, count_ext} + (LIM_W + 1)'(1)) >= {1'b0, lim};
  assign v_gt_min  = (v_r > min_r);
  assign smallest  = full ? min_r : '0;

  // Store write port: append while filling, overwrite the minimum when full.
  assign wr_en   = cmd.insert || (cmd.replace && v_gt_min);
  assign wr_addr = cmd.insert ? count_r[IDX_W-1:0] : min_idx_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= v_r;
    end
  end

  // Latched value, count and running sum.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r <= in_tdata[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
    end else if (cmd.load) begin
      if (in_tuser) begin
        count_r <= '0;
        sum_r   <= '0;
      end
    end else if (cmd.insert) begin
      count_r <= count_r + CNT_W'(1);
      sum_r   <= sum_r + SUM_W'(v_r);
    end else if (cmd.replace && v_gt_min) begin
      sum_r <= sum_r - SUM_W'(min_r) + SUM_W'(v_r);
    end
  end

  // Minimum search: one store read per cycle over entries below the count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scanning_r  <= 1'b0;
      rd_vld_r    <= 1'b0;
      scan_done_r <= 1'b0;
    end else begin
      scan_done_r <= rd_vld_r && rd_last_r;
      rd_vld_r    <= scanning_r;
      if (cmd.scan_start) begin
        scanning_r <= 1'b1;
      end else if (scanning_r && (scan_cnt_r == count_r - CNT_W'(1))) begin
        scanning_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_cnt_r <= '0;
    end else if (scanning_r) begin
      scan_cnt_r <= scan_cnt_r + CNT_W'(1);
    end
    if (scanning_r) begin
      rd_data_r <= mem[scan_cnt_r[IDX_W-1:0]];
      rd_idx_r  <= scan_cnt_r[IDX_W-1:0];
      rd_last_r <= (scan_cnt_r == count_r - CNT_W'(1));
    end
    // The first entry seeds the minimum; later ones win only when strictly lower.
    if (rd_vld_r && ((rd_idx_r == '0) || (rd_data_r < min_r))) begin
      min_r     <= rd_data_r;
      min_idx_r <= rd_idx_r;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sum_r    <= sum_r - SUM_W'(smallest);
      out_min_r    <= smallest;
      out_enough_r <= enough;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - SUM_W - VAL_W)'(0), out_min_r, out_sum_r};
  assign out_tuser  = out_enough_r;

  // Status to the controller.
  always_comb begin
    sts           = '0;
    sts.full      = full;
    sts.v_gt_min  = v_gt_min;
    sts.scan_done = scan_done_r;
    sts.scan_busy = scanning_r || rd_vld_r || scan_done_r;
    sts.out_free  = !out_valid_r || out_tready;
  end

endmodule

`default_nettype wire

>>> rtl/streaming_top_k_sum_tracker.sv
// Streaming top-L sum tracker: keeps the largest L samples and their sum.
//
// Channels: in_* takes one sample per request (tdata = value, tuser = restart).
// out_* returns one result per request (tdata = sum without smallest, then
// smallest held; tuser = enough held). cfg_wr_en/cfg_wr_data set keep_limit,
// the number of values kept (0 acts as 1, above CAPACITY acts as CAPACITY);
// write it only while no request is in flight.
// Throughput: one request is in work at a time; the next is taken only once
// the result is loaded. A request that only appends needs no minimum search;
// one that fills the store, or finds it full and is discarded, needs one; one
// that replaces the minimum needs two. The value store has a single read
// port: each minimum search reads one entry per cycle.
// Reset: held count and sum clear, keep_limit returns to 1; the value store
// keeps its contents, only entries below the count are ever read.
// Stall: a finished result waits in the output register while the next
// request is taken and worked on; that request's result waits for room.
// Depends on tks_pkg, tks_ctrl and tks_dp.
`timescale 1ns / 1ps
`default_nettype none

module streaming_top_k_sum_tracker #(
  parameter int CAPACITY = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Configuration: keep_limit
  input  wire logic                              cfg_wr_en,
  input  wire logic [tks_pkg::KL_W-1:0]          cfg_wr_data,
  // Input stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [tks_pkg::IN_TDATA_W-1:0]    in_tdata,   // [30:0] value, [31] zero
  input  wire logic                              in_tuser,   // [0] restart
  // Result stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [tks_pkg::OUT_TDATA_W-1:0]        out_tdata,  // [36:0] sum_without_smallest,
                                                             // [67:37] smallest_held, zeros
  output logic                                   out_tuser   // [0] enough_held
);
  import tks_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int LIM_W = (CNT_W > KL_W) ? CNT_W : KL_W;

  logic [KL_W-1:0]  keep_limit_r;
  logic [LIM_W-1:0] kl_ext;
  logic [LIM_W-1:0] lim;
  tks_cmd_t         cmd;
  tks_sts_t         sts;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_limit_r <= KL_W'(1);
    end else if (cfg_wr_en) begin
      keep_limit_r <= cfg_wr_data;
    end
  end

  // Effective limit, clamped to 1..CAPACITY.
  assign kl_ext = LIM_W'(keep_limit_r);
  always_comb begin
    if (kl_ext == '0) begin
      lim = LIM_W'(1);
    end else if (kl_ext > LIM_W'(CAPACITY)) begin
      lim = LIM_W'(CAPACITY);
    end else begin
      lim = kl_ext;
    end
  end

  tks_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tks_dp #(
    .CAPACITY (CAPACITY),
    .LIM_W    (LIM_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .lim        (lim),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // A result is only loaded when the output register has room.
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_tvalid || out_tready))
    else $error("result loaded over an untaken result");

  // After a request is taken, no second one is taken in the next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second request taken while one is in work");

  // A minimum search is never restarted while one is running.
  a_scan_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_start |-> !sts.scan_busy)
    else $error("minimum search started during a search");

  // Store writes and minimum searches never overlap.
  a_write_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.insert || cmd.replace) |-> !sts.scan_busy)
    else $error("store written during a minimum search");

endmodule

`default_nettype wire
